>>> rtl/urc_pkg.sv
// Shared types and constants for the ultrasonic ranging controller.
// Used by every module under rtl/; depends on nothing.
package urc_pkg;

  // Timing constants
  localparam int unsigned US_PER_MM   = 6;
  localparam int unsigned MIN_WAIT_US = 1000;
  localparam int unsigned TRIGGER_US  = 10;
  localparam int unsigned MS_TICKS    = 1000;

  // Field and register widths
  localparam int unsigned OP_W        = 2;
  localparam int unsigned MAX_DIST_W  = 14;
  localparam int unsigned PING_INT_W  = 10;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned US_IN_MS_W  = 10;
  localparam int unsigned TRIG_CNT_W  = 4;
  localparam int unsigned RANGE_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Ping delay is cut by the echo time in units of 1024 us
  localparam int unsigned CUT_SHIFT   = 10;
  localparam int unsigned CUT_W       = TIME_W - CUT_SHIFT;

  // Distance divider: reciprocal multiply, exact for durations below 2**DIV_IN_W
  localparam int unsigned DIV_IN_W    = 22;
  localparam int unsigned DIV_SHIFT   = 28;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(US_PER_MM) - 64'd1) / 64'(US_PER_MM);
  localparam int unsigned DIV_RECIP_W = DIV_SHIFT + 1;
  localparam int unsigned DIV_PROD_W  = DIV_IN_W + DIV_RECIP_W;
  // Durations at or above this give a distance beyond the 15-bit range
  localparam logic [TIME_W-1:0] SAT_DUR = TIME_W'(US_PER_MM * 32768);

  // Precomputed constants at working widths
  localparam logic [TIME_W-1:0]     US_PER_MM_T  = TIME_W'(US_PER_MM);
  localparam logic [TIME_W-1:0]     MIN_WAIT_T   = TIME_W'(MIN_WAIT_US);
  localparam logic [TRIG_CNT_W-1:0] TRIGGER_LOAD = TRIG_CNT_W'(TRIGGER_US - 1);
  localparam logic [US_IN_MS_W-1:0] US_IN_MS_TOP = US_IN_MS_W'(MS_TICKS - 1);

  // Reset values of the configuration registers
  localparam logic [MAX_DIST_W-1:0] MAX_DIST_RST = MAX_DIST_W'(4000);
  localparam logic [PING_INT_W-1:0] PING_INT_RST = PING_INT_W'(50);

  // Reported range codes
  localparam logic signed [RANGE_W-1:0] RANGE_NONE    = -16'sd2;
  localparam logic signed [RANGE_W-1:0] RANGE_TIMEOUT = -16'sd1;
  localparam logic signed [RANGE_W-1:0] RANGE_SAT     = 16'sd32767;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INT = 2'd1;

  // Input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2
  } urc_op_t;

  // What a step does to the reported range
  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_DIST    = 2'd1,
    RES_TIMEOUT = 2'd2,
    RES_CLEAR   = 2'd3
  } urc_res_t;

  // Step outcome handed from the ranging core to the output stage
  typedef struct packed {
    logic              trigger;
    urc_res_t          kind;
    logic              active;
    logic [TIME_W-1:0] duration;
  } urc_mid_t;

endpackage

>>> rtl/ultrasonic_ranging_controller.sv
// Top level of the ultrasonic ranging controller: handshake, configuration
// registers, input register. Depends on urc_pkg, urc_core and urc_fmt.
//
// Usage
//   Input channel: one transaction per microsecond tick (in_operation = tick,
//   in_echo_level = sampled echo pin) or an enable / disable command.
//   Output channel: one transaction per input transaction, carrying the trigger
//   pin drive, the latest range in mm (-1 timeout, -2 nothing since enable),
//   a flag for a fresh result and the enabled status.
//   Configuration: cfg_index 0 is the range limit in mm, 1 the ping interval
//   in ms; cfg_ready is always high. Write only while the block is idle.
// Pipeline and throughput
//   Three register stages: input, ranging core, output. A result is presented
//   once it has passed all three, and one transaction is taken every cycle
//   while in_stall is low; the range divide is a single reciprocal multiply.
// Reset and stall
//   Synchronous reset empties all stages, disables ranging and sets the range
//   to -2. A stall on the output holds the presented result; the pipe keeps
//   accepting until its empty stages are filled, then raises in_stall.
module ultrasonic_ranging_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [urc_pkg::OP_W-1:0]           in_operation,
  input  logic                               in_echo_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_trigger,
  output logic signed [urc_pkg::RANGE_W-1:0] out_distance_mm,
  output logic                               out_result_valid,
  output logic                               out_active,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [urc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [urc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import urc_pkg::*;

  logic [MAX_DIST_W-1:0] max_dist_r;
  logic [PING_INT_W-1:0] ping_int_r;
  logic                  in_v_r, mid_v_r, out_v_r;
  logic [OP_W-1:0]       op_r;
  logic                  echo_r;
  logic                  out_rdy, mid_rdy, mid_load, out_load, in_load;
  urc_mid_t              mid;

  // Stage flow control: each stage fills when it is empty or the one after can move
  assign out_rdy  = ~out_v_r | ~out_stall;
  assign mid_rdy  = ~mid_v_r | out_rdy;
  assign mid_load = in_v_r & mid_rdy;
  assign out_load = mid_v_r & out_rdy;
  assign in_stall = in_v_r & ~mid_rdy;
  assign in_load  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_load) begin
        in_v_r <= 1'b1;
      end else if (mid_load) begin
        in_v_r <= 1'b0;
      end
      if (mid_load) begin
        mid_v_r <= 1'b1;
      end else if (out_load) begin
        mid_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r   <= in_operation;
      echo_r <= in_echo_level;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAX_DIST_RST;
      ping_int_r <= PING_INT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_DIST) begin
        max_dist_r <= cfg_data[MAX_DIST_W-1:0];
      end
      if (cfg_index == CFG_PING_INT) begin
        ping_int_r <= cfg_data[PING_INT_W-1:0];
      end
    end
  end

  urc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (mid_load),
    .op_i       (op_r),
    .echo_i     (echo_r),
    .max_dist_i (max_dist_r),
    .ping_int_i (ping_int_r),
    .mid_o      (mid)
  );

  urc_fmt u_fmt (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (out_load),
    .mid_i          (mid),
    .trigger_o      (out_trigger),
    .distance_o     (out_distance_mm),
    .result_valid_o (out_result_valid),
    .active_o       (out_active)
  );

  assign out_valid = out_v_r;

endmodule

>>> rtl/urc_core.sv
// Ranging core: clocks, echo edge timing, trigger pulse and ping scheduling.
// One step per loaded transaction; outcome registered in a urc_mid_t.
// Depends on urc_pkg.
module urc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_i,
  input  logic [urc_pkg::OP_W-1:0]       op_i,
  input  logic                           echo_i,
  input  logic [urc_pkg::MAX_DIST_W-1:0] max_dist_i,
  input  logic [urc_pkg::PING_INT_W-1:0] ping_int_i,
  output urc_pkg::urc_mid_t              mid_o
);
  import urc_pkg::*;

  typedef enum logic [1:0] {
    MODE_DISABLED  = 2'd0,
    MODE_WAIT_PING = 2'd1,
    MODE_READING   = 2'd2
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [TIME_W-1:0]      now_us_r, now_us_nxt;
  logic [US_IN_MS_W-1:0]  us_in_ms_r, us_in_ms_nxt;
  logic [TIME_W-1:0]      now_ms_r, now_ms_nxt;
  logic [TIME_W-1:0]      next_ping_r, next_ping_nxt;
  logic                   echo_prev_r, echo_prev_nxt;
  // now_us - rise time + 1: the echo length if the echo falls on the next tick
  logic [TIME_W-1:0]      elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]      deadline_r, deadline_nxt;
  logic [TIME_W-1:0]      min_wait_r, min_wait_nxt;
  logic [TRIG_CNT_W-1:0]  trig_left_r, trig_left_nxt;
  urc_mid_t               mid_r, mid_nxt;

  logic [TIME_W-1:0]      now_us_inc;
  logic                   ms_roll;
  logic                   rise, fall;
  logic [TIME_W-1:0]      reach_us;
  logic [CUT_W-1:0]       cut;
  logic [PING_INT_W-1:0]  delay_short;

  assign now_us_inc = now_us_r + 1'b1;
  assign ms_roll    = (us_in_ms_r >= US_IN_MS_TOP);
  assign rise       = echo_i & ~echo_prev_r;
  assign fall       = ~echo_i & echo_prev_r;
  assign reach_us   = TIME_W'(max_dist_i) * US_PER_MM_T;

  // Ping delay shortened by the echo just measured, floored at zero
  assign cut         = elapsed_r[TIME_W-1:CUT_SHIFT];
  assign delay_short = (cut >= CUT_W'(ping_int_i)) ? '0 : ping_int_i - cut[PING_INT_W-1:0];

  // Step logic
  always_comb begin
    mode_nxt      = mode_r;
    now_us_nxt    = now_us_r;
    us_in_ms_nxt  = us_in_ms_r;
    now_ms_nxt    = now_ms_r;
    next_ping_nxt = next_ping_r;
    echo_prev_nxt = echo_prev_r;
    elapsed_nxt   = elapsed_r;
    deadline_nxt  = deadline_r;
    min_wait_nxt  = min_wait_r;
    trig_left_nxt = trig_left_r;
    mid_nxt.trigger  = (trig_left_r != '0);
    mid_nxt.kind     = RES_NONE;
    mid_nxt.duration = elapsed_r;
    mid_nxt.active   = 1'b0;

    unique case (op_i)
      OP_TICK: begin
        // clocks
        now_us_nxt   = now_us_inc;
        us_in_ms_nxt = ms_roll ? '0 : us_in_ms_r + 1'b1;
        now_ms_nxt   = ms_roll ? now_ms_r + 1'b1 : now_ms_r;

        // echo edges
        if (rise) begin
          elapsed_nxt  = TIME_W'(1);
          deadline_nxt = now_us_inc + reach_us;
        end else begin
          elapsed_nxt  = elapsed_r + 1'b1;
        end
        echo_prev_nxt = echo_i;

        // trigger pulse countdown
        if (trig_left_r != '0) begin
          trig_left_nxt = trig_left_r - 1'b1;
        end

        // ranging sequence
        unique case (mode_r)
          MODE_WAIT_PING: begin
            if (next_ping_r < now_ms_nxt) begin
              mid_nxt.trigger = 1'b1;
              trig_left_nxt   = TRIGGER_LOAD;
              min_wait_nxt    = now_us_inc + MIN_WAIT_T;
              mode_nxt        = MODE_READING;
            end
          end
          MODE_READING: begin
            // any falling edge here is taken as the end of this ping's echo
            if (fall) begin
              mid_nxt.kind  = RES_DIST;
              next_ping_nxt = now_ms_nxt + TIME_W'(delay_short);
              mode_nxt      = MODE_WAIT_PING;
            end else if (deadline_nxt < now_us_inc && min_wait_r < now_us_inc) begin
              mid_nxt.kind  = RES_TIMEOUT;
              next_ping_nxt = now_ms_nxt + TIME_W'(ping_int_i);
              mode_nxt      = MODE_WAIT_PING;
            end
          end
          default: begin
          end
        endcase
      end
      OP_ENABLE: begin
        next_ping_nxt = now_ms_r + TIME_W'(ping_int_i);
        mid_nxt.kind  = RES_CLEAR;
        mode_nxt      = MODE_WAIT_PING;
      end
      OP_DISABLE: begin
        mode_nxt = MODE_DISABLED;
      end
      default: begin
      end
    endcase

    mid_nxt.active = (mode_nxt != MODE_DISABLED);
  end

  // State and registered outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DISABLED;
      now_us_r    <= '0;
      us_in_ms_r  <= '0;
      now_ms_r    <= '0;
      next_ping_r <= '0;
      echo_prev_r <= 1'b0;
      elapsed_r   <= TIME_W'(1);
      deadline_r  <= '0;
      min_wait_r  <= '0;
      trig_left_r <= '0;
    end else if (load_i) begin
      mode_r      <= mode_nxt;
      now_us_r    <= now_us_nxt;
      us_in_ms_r  <= us_in_ms_nxt;
      now_ms_r    <= now_ms_nxt;
      next_ping_r <= next_ping_nxt;
      echo_prev_r <= echo_prev_nxt;
      elapsed_r   <= elapsed_nxt;
      deadline_r  <= deadline_nxt;
      min_wait_r  <= min_wait_nxt;
      trig_left_r <= trig_left_nxt;
    end
    if (load_i) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_o = mid_r;

endmodule

>>> rtl/urc_fmt.sv
// Output stage: converts echo time to millimetres and holds the reported range.
// Reciprocal multiply by 1/US_PER_MM with saturation. Depends on urc_pkg.
module urc_fmt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load_i,
  input  urc_pkg::urc_mid_t                  mid_i,
  output logic                               trigger_o,
  output logic signed [urc_pkg::RANGE_W-1:0] distance_o,
  output logic                               result_valid_o,
  output logic                               active_o
);
  import urc_pkg::*;

  logic signed [RANGE_W-1:0] range_r, range_nxt;
  logic                      trigger_r, result_valid_r, active_r;
  logic [DIV_PROD_W-1:0]     prod;
  logic                      sat;

  // duration / US_PER_MM, exact below the saturation point
  assign prod = DIV_PROD_W'(mid_i.duration[DIV_IN_W-1:0]) *
                DIV_PROD_W'(DIV_RECIP_W'(DIV_RECIP));
  assign sat  = (mid_i.duration >= SAT_DUR);

  // Range update
  always_comb begin
    range_nxt = range_r;
    unique case (mid_i.kind)
      RES_DIST:    range_nxt = sat ? RANGE_SAT :
                               {1'b0, prod[DIV_SHIFT +: (RANGE_W - 1)]};
      RES_TIMEOUT: range_nxt = RANGE_TIMEOUT;
      RES_CLEAR:   range_nxt = RANGE_NONE;
      default:     range_nxt = range_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_NONE;
    end else if (load_i) begin
      range_r <= range_nxt;
    end
    if (load_i) begin
      trigger_r      <= mid_i.trigger;
      result_valid_r <= (mid_i.kind == RES_DIST) || (mid_i.kind == RES_TIMEOUT);
      active_r       <= mid_i.active;
    end
  end

  assign trigger_o      = trigger_r;
  assign distance_o     = range_r;
  assign result_valid_o = result_valid_r;
  assign active_o       = active_r;

endmodule

>>> rtl/urc_checker.sv
// Port-level checks for the ultrasonic ranging controller, bound to the top.
// Depends on urc_pkg and ultrasonic_ranging_controller.
module urc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [urc_pkg::RANGE_W-1:0] out_distance_mm,
  input logic                               out_result_valid,
  input logic                               out_active
);
  import urc_pkg::*;

  // A held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_mm))
    else $error("stalled result changed");

  // A fresh result is a distance or a timeout, never the no-result code, and comes while active
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_valid |-> out_distance_mm != RANGE_NONE && out_active)
    else $error("fresh result with no-result code or while disabled");

  // An empty output stage never back-pressures the input
  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Output stage comes out of reset empty
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind ultrasonic_ranging_controller urc_checker u_urc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_distance_mm  (out_distance_mm),
  .out_result_valid (out_result_valid),
  .out_active       (out_active)
);
